// File: hw/rtl/dl_pkg.sv
`default_nettype none
package dl_pkg;

	localparam int DATA_W = 16;
	localparam int ACC_W  = 40;
	localparam int FRAC_W = 12;
	localparam int CNT_W  = 7;
	localparam int MODE_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] REQ_WEIGHT = 2'd0;
	localparam logic [1:0] REQ_BIAS   = 2'd1;
	localparam logic [1:0] REQ_ELEM   = 2'd2;

	localparam logic [MODE_W-1:0] ACT_LINEAR  = 2'd0;
	localparam logic [MODE_W-1:0] ACT_RELU    = 2'd1;
	localparam logic [MODE_W-1:0] ACT_SIGMOID = 2'd2;
	localparam logic [MODE_W-1:0] ACT_TANH    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACT_MODE     = 2'd2;

	// Sigmoid breakpoints at k = -8..8, Q0.12.
	function automatic logic [11:0] sig_lut(input logic [4:0] k);
		logic [11:0] r;
		case (k)
			5'd0:  r = 12'd1;
			5'd1:  r = 12'd4;
			5'd2:  r = 12'd10;
			5'd3:  r = 12'd27;
			5'd4:  r = 12'd74;
			5'd5:  r = 12'd194;
			5'd6:  r = 12'd488;
			5'd7:  r = 12'd1102;
			5'd8:  r = 12'd2048;
			5'd9:  r = 12'd2994;
			5'd10: r = 12'd3608;
			5'd11: r = 12'd3902;
			5'd12: r = 12'd4022;
			5'd13: r = 12'd4069;
			5'd14: r = 12'd4086;
			5'd15: r = 12'd4092;
			default: r = 12'd4095;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/dl_if.sv
`default_nettype none
interface dl_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [5:0]  row_index;
	logic [5:0]  col_index;
	logic signed [15:0] value;
	modport source (output valid, req_type, row_index, col_index, value, input ready);
	modport sink (input valid, req_type, row_index, col_index, value, output ready);
endinterface

interface dl_rsp_if;
	logic        valid;
	logic        ready;
	logic [5:0]  out_index;
	logic signed [15:0] out_value;
	logic        out_last;
	modport source (output valid, out_index, out_value, out_last, input ready);
	modport sink (input valid, out_index, out_value, out_last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/dl_cell.sv
`default_nettype none
// One accumulator slot of the rotating ring.
module dl_cell (
	input  wire logic clk,
	input  wire logic shift,
	input  wire logic signed [dl_pkg::ACC_W-1:0] d,
	output logic signed [dl_pkg::ACC_W-1:0] q
);
	logic signed [dl_pkg::ACC_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			acc_q <= d;
		end
	end

	assign q = acc_q;
endmodule
`default_nettype wire

// File: hw/rtl/dl_act.sv
`default_nettype none
// Two-stage activation: rounding and segment lookup, then interpolation.
module dl_act (
	input  wire logic clk,
	input  wire logic load,
	input  wire logic signed [dl_pkg::ACC_W-1:0] acc,
	input  wire logic [dl_pkg::MODE_W-1:0] mode,
	output logic signed [dl_pkg::DATA_W-1:0] y
);
	function automatic logic [15:0] sat16(input logic signed [29:0] v);
		logic [15:0] r;
		if (v > 30'sd32767) r = 16'h7FFF;
		else if (v < -30'sd32768) r = 16'h8000;
		else r = v[15:0];
		return r;
	endfunction

	logic signed [40:0] rnd;
	logic signed [28:0] x;
	logic [15:0] lin, relu, arg, off;
	logic [11:0] t0, t1, dt;

	logic [1:0]  mode_q;
	logic [15:0] lin_q;
	logic [15:0] relu_q;
	logic [11:0] t0_q;
	logic [9:0]  d_q;
	logic [11:0] f_q;

	logic [21:0] prod;
	logic [12:0] sig;

	always_comb begin
		rnd  = {acc[dl_pkg::ACC_W-1], acc} + 41'sd2048;
		x    = rnd[40:12];
		lin  = sat16({x[28], x});
		relu = x[28] ? 16'h0000 : lin;
		arg  = (mode == dl_pkg::ACT_TANH) ? sat16({x, 1'b0}) : lin;
		off  = arg ^ 16'h8000;
		t0   = dl_pkg::sig_lut({1'b0, off[15:12]});
		t1   = dl_pkg::sig_lut({1'b0, off[15:12]} + 5'd1);
		dt   = t1 - t0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mode_q <= mode;
			lin_q  <= lin;
			relu_q <= relu;
			t0_q   <= t0;
			d_q    <= dt[9:0];
			f_q    <= off[11:0];
		end
	end

	always_comb begin
		prod = d_q * f_q;
		sig  = {1'b0, t0_q} + {3'b000, prod[21:12]};
		case (mode_q)
			dl_pkg::ACT_LINEAR:  y = lin_q;
			dl_pkg::ACT_RELU:    y = relu_q;
			dl_pkg::ACT_SIGMOID: y = {3'b000, sig};
			default:             y = {2'b00, sig, 1'b0} - 16'sd4096;
		endcase
	end
endmodule
`default_nettype wire

// File: hw/rtl/dense_layer_with_activation_top.sv
`default_nettype none
// Flow: a vector issues nin * MAX_OUTPUTS products through the shared MAC and waits for the
// MAC pipeline to empty, then each result takes two activation steps and the handoff.
// Throughput: one request per cycle for weight, bias and non-final element requests; the
// final element blocks further requests for the whole computation and drain.
// Reset: arst_n clears control and the configuration registers (input_count and output_count
// 64, relu); the weight, bias and input stores are not cleared and hold garbage until written.
module dense_layer_with_activation_top #(
	parameter int MAX_INPUTS  = 64,
	parameter int MAX_OUTPUTS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [dl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dl_pkg::CNT_W-1:0] cfg_data,
	dl_req_if.sink   req,
	dl_rsp_if.source rsp
);
	localparam int RW   = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
	localparam int CW   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int CMPW = (CW > 7) ? CW : 7;
	localparam int AW   = RW + CW;
	localparam int ACCW = dl_pkg::ACC_W;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_RUN     = 3'd1;
	localparam logic [2:0] ST_DRAIN_A = 3'd2;
	localparam logic [2:0] ST_DRAIN_B = 3'd3;
	localparam logic [2:0] ST_OUT     = 3'd4;

	// Configuration registers, to be written only while the block is idle; the block does not enforce it.
	logic [6:0] in_cnt_q, out_cnt_q;
	logic [1:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= 7'd64;
			out_cnt_q <= 7'd64;
			mode_q    <= dl_pkg::ACT_RELU;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dl_pkg::CFG_INPUT_COUNT:  in_cnt_q  <= cfg_data;
				dl_pkg::CFG_OUTPUT_COUNT: out_cnt_q <= cfg_data;
				dl_pkg::CFG_ACT_MODE:     mode_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Counts of zero act as one and counts above the store size act as the size.
	logic [CMPW-1:0] nin_m1;
	logic [RW-1:0]   nout_m1;
	always_comb begin
		if (in_cnt_q == 7'd0) nin_m1 = '0;
		else if (32'(in_cnt_q) > MAX_INPUTS) nin_m1 = CMPW'(MAX_INPUTS - 1);
		else nin_m1 = CMPW'(in_cnt_q - 7'd1);
		if (out_cnt_q == 7'd0) nout_m1 = '0;
		else if (32'(out_cnt_q) > MAX_OUTPUTS) nout_m1 = RW'(MAX_OUTPUTS - 1);
		else nout_m1 = RW'(out_cnt_q - 7'd1);
	end

	logic [2:0] state_q;
	logic req_acc, row_ok, col_ok, trigger;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign row_ok    = 32'(req.row_index) < MAX_OUTPUTS;
	assign col_ok    = 32'(req.col_index) < MAX_INPUTS;
	// The element at the last used position starts the computation.
	assign trigger   = req_acc && (req.req_type == dl_pkg::REQ_ELEM) && col_ok &&
		(CMPW'(req.col_index) == nin_m1);

	// Stores: one write port for requests, one registered read port for the MAC feed.
	logic signed [15:0] wmem [(MAX_OUTPUTS << CW)];
	logic signed [15:0] bmem [MAX_OUTPUTS];
	logic signed [15:0] xmem [MAX_INPUTS];

	always_ff @(posedge clk) begin
		if (req_acc && row_ok && col_ok && req.req_type == dl_pkg::REQ_WEIGHT) begin
			wmem[AW'({RW'(req.row_index), CW'(req.col_index)})] <= req.value;
		end
		if (req_acc && row_ok && req.req_type == dl_pkg::REQ_BIAS) begin
			bmem[RW'(req.row_index)] <= req.value;
		end
		if (req_acc && col_ok && req.req_type == dl_pkg::REQ_ELEM) begin
			xmem[CW'(req.col_index)] <= req.value;
		end
	end

	// Issue counters walk every ring slot for each input position, so the ring
	// comes back aligned after each pass.
	logic [RW-1:0] ci_q;
	logic [CW-1:0] cj_q;
	logic          iss_done_q;
	logic          issuing;
	assign issuing = (state_q == ST_RUN) && !iss_done_q;

	logic signed [15:0] w_s1, b_s1, x_s1, b_s2;
	logic               first_s1, first_s2, v_s1, v_s2;
	logic signed [31:0] prod_s2;

	always_ff @(posedge clk) begin
		w_s1     <= wmem[{ci_q, cj_q}];
		b_s1     <= bmem[ci_q];
		x_s1     <= xmem[cj_q];
		first_s1 <= (cj_q == '0);
		prod_s2  <= w_s1 * x_s1;
		b_s2     <= b_s1;
		first_s2 <= first_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issuing;
			v_s2 <= v_s1;
		end
	end

	// Accumulator ring: cell 0 is the head that meets the MAC, the tail takes the sum.
	logic signed [ACCW-1:0] ring [MAX_OUTPUTS];
	logic signed [ACCW-1:0] base, sum_sat, tail_d;
	logic signed [ACCW:0]   sum;
	logic                   ring_shift;

	always_comb begin
		base = first_s2 ? {{(ACCW-28){b_s2[15]}}, b_s2, 12'd0} : ring[0];
		sum  = {base[ACCW-1], base} + {{(ACCW-31){prod_s2[31]}}, prod_s2};
		if (sum[ACCW] != sum[ACCW-1])
			sum_sat = sum[ACCW] ? {1'b1, {(ACCW-1){1'b0}}} : {1'b0, {(ACCW-1){1'b1}}};
		else
			sum_sat = sum[ACCW-1:0];
		tail_d = (state_q == ST_RUN) ? sum_sat : ring[0];
	end

	assign ring_shift = v_s2 || (state_q == ST_OUT && rsp.ready);

	for (genvar k = 0; k < MAX_OUTPUTS; k++) begin : g_ring
		dl_cell u_cell (
			.clk   (clk),
			.shift (ring_shift),
			.d     ((k == MAX_OUTPUTS - 1) ? tail_d : ring[(k + 1) % MAX_OUTPUTS]),
			.q     (ring[k])
		);
	end

	// Activation of the head cell during the drain.
	logic signed [15:0] act_y;
	dl_act u_act (
		.clk  (clk),
		.load (state_q == ST_DRAIN_A),
		.acc  (ring[0]),
		.mode (mode_q),
		.y    (act_y)
	);

	logic [RW-1:0]      oi_q;
	logic [5:0]         out_index_q;
	logic signed [15:0] out_value_q;
	logic               out_last_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN_B) begin
			out_index_q <= 6'(oi_q);
			out_value_q <= act_y;
			out_last_q  <= (oi_q == nout_m1);
		end
	end

	assign rsp.valid     = (state_q == ST_OUT);
	assign rsp.out_index = out_index_q;
	assign rsp.out_value = out_value_q;
	assign rsp.out_last  = out_last_q;

	// Sequencer: idle takes requests, run feeds the MAC, drain emits results one by one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ci_q       <= '0;
			cj_q       <= '0;
			iss_done_q <= 1'b0;
			oi_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (trigger) begin
						state_q    <= ST_RUN;
						ci_q       <= '0;
						cj_q       <= '0;
						iss_done_q <= 1'b0;
					end
				end
				ST_RUN: begin
					if (issuing) begin
						if (ci_q == RW'(MAX_OUTPUTS - 1)) begin
							ci_q <= '0;
							if (CMPW'(cj_q) == nin_m1) iss_done_q <= 1'b1;
							else cj_q <= cj_q + CW'(1);
						end else begin
							ci_q <= ci_q + RW'(1);
						end
					end else if (!v_s1 && !v_s2) begin
						state_q <= ST_DRAIN_A;
						oi_q    <= '0;
					end
				end
				ST_DRAIN_A: state_q <= ST_DRAIN_B;
				ST_DRAIN_B: state_q <= ST_OUT;
				ST_OUT: begin
					if (rsp.ready) begin
						if (out_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							oi_q    <= oi_q + RW'(1);
							state_q <= ST_DRAIN_A;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The MAC pipeline is empty whenever requests are taken.
	assert property (@(posedge clk) disable iff (!arst_n) req.ready |-> !v_s1 && !v_s2)
		else $error("request taken with MAC pipeline busy");
	// The last result returns the block to taking requests.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && rsp.out_last |=> req.ready)
		else $error("block not idle after last result");
	// Products only reach the ring while the sequencer is running.
	assert property (@(posedge clk) disable iff (!arst_n) v_s2 |-> state_q == ST_RUN)
		else $error("MAC result outside run phase");
endmodule
`default_nettype wire

// File: tb/dense_layer_with_activation_top_tb.sv
`default_nettype none
module dense_layer_with_activation_top_tb;

	// One request as the driver will offer it.
	typedef struct {
		logic [1:0]         kind;
		logic [5:0]         row;
		logic [5:0]         col;
		logic signed [15:0] val;
	} layer_req_t;

	// One neuron result as the block should report it.
	typedef struct {
		logic [5:0]         idx;
		logic signed [15:0] val;
		logic               last;
	} neuron_out_t;

	localparam longint ACC_HI = (longint'(1) << 39) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;

	// Request code that the block does not know and must ignore.
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [dl_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dl_pkg::CNT_W-1:0] cfg_data;

	dl_req_if req_ch();
	dl_rsp_if rsp_ch();

	dense_layer_with_activation_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Requests waiting to be offered, and neuron results still owed by the block.
	layer_req_t  pending_reqs[$];
	neuron_out_t owed_outputs[$];

	// The predictor's own copy of the stores and registers.
	logic signed [15:0] mdl_weight [64][64];
	logic signed [15:0] mdl_bias [64];
	logic signed [15:0] mdl_vec [64];
	logic [6:0] mdl_nin;
	logic [6:0] mdl_nout;
	logic [1:0] mdl_act;

	// Which store entries the stimulus has already filled, so that a vector
	// never pulls in an entry that was never written.
	bit wrote_w [64][64];
	bit wrote_b [64];
	bit wrote_v [64];

	bit req_taken;
	bit calm;
	bit hold_go;
	bit hold_used;
	int hold_left;
	int errors;
	int reqs_sent;
	int outs_checked;
	int vectors_run;
	int queued_items;

	// Sigmoid breakpoints at k = -8..8 in Q0.12.
	int sig_pts [17] = '{1, 4, 10, 27, 74, 194, 488, 1102, 2048,
		2994, 3608, 3902, 4022, 4069, 4086, 4092, 4095};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The run is cut off here if the block ever stops making progress.
	initial begin
		#(12 * 20000000);
		$display("Verification failed");
		$finish;
	end

	function automatic int eff_count(logic [6:0] c);
		if (c == 0)
			return 1;
		if (c > 64)
			return 64;
		return int'(c);
	endfunction

	function automatic longint sat16(longint x);
		if (x > 32767)
			return 32767;
		if (x < -32768)
			return -32768;
		return x;
	endfunction

	// Piecewise-linear sigmoid over 16 unit segments covering [-8, 8).
	function automatic longint sigmoid_pwl(longint x);
		longint off;
		longint seg;
		longint frac;
		longint slope;
		off = sat16(x) + 32768;
		seg = off >> 12;
		frac = off & 4095;
		slope = sig_pts[seg + 1] - sig_pts[seg];
		return sig_pts[seg] + ((slope * frac) >> 12);
	endfunction

	function automatic logic signed [15:0] activate(longint x);
		longint y;
		case (mdl_act)
			dl_pkg::ACT_RELU:    y = (x < 0) ? 0 : x;
			dl_pkg::ACT_SIGMOID: y = sigmoid_pwl(x);
			dl_pkg::ACT_TANH:    y = 2 * sigmoid_pwl(2 * x) - 4096;
			default:             y = x;
		endcase
		return 16'(sat16(y));
	endfunction

	// Runs the whole layer for the current vector and queues every neuron result.
	task automatic run_layer();
		int nin;
		int nout;
		longint acc;
		neuron_out_t o;
		nin = eff_count(mdl_nin);
		nout = eff_count(mdl_nout);
		for (int i = 0; i < nout; i++) begin
			acc = longint'(mdl_bias[i]) * 4096;
			for (int j = 0; j < nin; j++) begin
				acc += longint'(mdl_weight[i][j]) * longint'(mdl_vec[j]);
				if (acc > ACC_HI)
					acc = ACC_HI;
				if (acc < ACC_LO)
					acc = ACC_LO;
			end
			o.idx = 6'(i);
			o.val = activate((acc + 2048) >>> 12);
			o.last = (i == nout - 1);
			owed_outputs = {owed_outputs, o};
		end
		vectors_run++;
	endtask

	// Applies one accepted request to the predictor's stores.
	task automatic apply_req(layer_req_t r);
		case (r.kind)
			dl_pkg::REQ_WEIGHT: mdl_weight[r.row][r.col] = r.val;
			dl_pkg::REQ_BIAS:   mdl_bias[r.row] = r.val;
			dl_pkg::REQ_ELEM: begin
				mdl_vec[r.col] = r.val;
				if (r.col == eff_count(mdl_nin) - 1)
					run_layer();
			end
			default: ;
		endcase
	endtask

	// Request driver: a new request goes out at the falling edge once the last
	// one was taken, with random gaps unless the run is in a calm stretch.
	always @(negedge clk) begin
		layer_req_t r;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= dl_pkg::REQ_WEIGHT;
			req_ch.row_index <= '0;
			req_ch.col_index <= '0;
			req_ch.value <= '0;
		end else if (!req_ch.valid || req_taken) begin
			if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 36)) begin
				r = pending_reqs.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.req_type <= r.kind;
				req_ch.row_index <= r.row;
				req_ch.col_index <= r.col;
				req_ch.value <= r.val;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus one long hold-off so that the
	// block backs up and stops taking requests.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (hold_go && !hold_used) begin
				hold_used <= 1'b1;
				hold_left <= 1500;
				rsp_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(99) >= 36);
			end
		end
	end

	// Monitor: accepted requests feed the predictor; accepted results are
	// checked against the oldest owed result.
	always @(posedge clk) begin
		layer_req_t r;
		neuron_out_t e;
		req_taken <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			r.kind = req_ch.req_type;
			r.row = req_ch.row_index;
			r.col = req_ch.col_index;
			r.val = req_ch.value;
			apply_req(r);
			reqs_sent++;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (owed_outputs.size() == 0) begin
				$error("unexpected result: out_index %0d out_value %0d", rsp_ch.out_index,
					rsp_ch.out_value);
				errors++;
			end else begin
				e = owed_outputs.pop_front();
				if (rsp_ch.out_index !== e.idx) begin
					$error("out_index: expected %0d, actual %0d", e.idx, rsp_ch.out_index);
					errors++;
				end
				if (rsp_ch.out_value !== e.val) begin
					$error("out_value: expected %0d, actual %0d", e.val, rsp_ch.out_value);
					errors++;
				end
				if (rsp_ch.out_last !== e.last) begin
					$error("out_last: expected %0d, actual %0d", e.last, rsp_ch.out_last);
					errors++;
				end
			end
			outs_checked++;
		end
	end

	// Mix of full-range, extreme and small values; small ones keep the
	// sigmoid and tanh away from their flat ends.
	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: begin
				case ($urandom_range(3))
					0: return 16'sh7fff;
					1: return 16'sh8000;
					2: return 16'sh0000;
					default: return 16'shffff;
				endcase
			end
			default: return 16'($urandom_range(8191)) - 16'sd4096;
		endcase
	endfunction

	task automatic queue_req(logic [1:0] kind, int row, int col, logic signed [15:0] val);
		layer_req_t r;
		r.kind = kind;
		r.row = 6'(row);
		r.col = 6'(col);
		r.val = val;
		pending_reqs = {pending_reqs, r};
		queued_items++;
		case (kind)
			dl_pkg::REQ_WEIGHT: wrote_w[row][col] = 1'b1;
			dl_pkg::REQ_BIAS:   wrote_b[row] = 1'b1;
			dl_pkg::REQ_ELEM:   wrote_v[col] = 1'b1;
			default: ;
		endcase
	endtask

	// One well-formed vector with random content: fills whatever the current
	// sizes need, rewrites some of it, sprinkles in noise, then sends the
	// element that sets off the computation.
	task automatic queue_vector();
		int nin;
		int nout;
		int c;
		nin = eff_count(mdl_nin);
		nout = eff_count(mdl_nout);
		for (int r = 0; r < nout; r++) begin
			if (!wrote_b[r] || $urandom_range(3) == 0)
				queue_req(dl_pkg::REQ_BIAS, r, $urandom_range(63), pick_value());
			for (c = 0; c < nin; c++)
				if (!wrote_w[r][c] || $urandom_range(7) == 0)
					queue_req(dl_pkg::REQ_WEIGHT, r, c, pick_value());
		end
		// Noise: weight writes anywhere, unknown requests and elements beyond the count.
		for (int k = $urandom_range(3); k > 0; k--) begin
			case ($urandom_range(2))
				0: queue_req(dl_pkg::REQ_WEIGHT, $urandom_range(63), $urandom_range(63),
					pick_value());
				1: queue_req(REQ_UNKNOWN, $urandom_range(63), $urandom_range(63), 16'($urandom));
				default: begin
					if (nin < 64)
						queue_req(dl_pkg::REQ_ELEM, $urandom_range(63), $urandom_range(63, nin),
							pick_value());
				end
			endcase
		end
		for (c = 0; c < nin - 1; c++)
			if (!wrote_v[c] || $urandom_range(1) == 0)
				queue_req(dl_pkg::REQ_ELEM, $urandom_range(63), c, pick_value());
		queue_req(dl_pkg::REQ_ELEM, $urandom_range(63), nin - 1, pick_value());
	endtask

	// Lets everything drain so that a register write meets an idle block.
	task automatic wait_idle();
		while (pending_reqs.size() > 0 || req_ch.valid || owed_outputs.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [dl_pkg::CFG_IDX_W-1:0] idx, logic [6:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dl_pkg::CFG_INPUT_COUNT:  mdl_nin = data;
			dl_pkg::CFG_OUTPUT_COUNT: mdl_nout = data;
			default:                  mdl_act = data[1:0];
		endcase
	endtask

	task automatic set_layer(logic [6:0] nin, logic [6:0] nout, logic [1:0] act);
		wait_idle();
		write_reg(dl_pkg::CFG_INPUT_COUNT, nin);
		write_reg(dl_pkg::CFG_OUTPUT_COUNT, nout);
		write_reg(dl_pkg::CFG_ACT_MODE, 7'(act));
	endtask

	// Directed vector for a single input and two neurons: neuron 0 sees
	// bias b0 and weight w0, neuron 1 sees b1 and w1.
	task automatic queue_pair(logic signed [15:0] b0, logic signed [15:0] w0,
			logic signed [15:0] b1, logic signed [15:0] w1, logic signed [15:0] x);
		queue_req(dl_pkg::REQ_BIAS, 0, 0, b0);
		queue_req(dl_pkg::REQ_WEIGHT, 0, 0, w0);
		queue_req(dl_pkg::REQ_BIAS, 1, 63, b1);
		queue_req(dl_pkg::REQ_WEIGHT, 1, 0, w1);
		queue_req(dl_pkg::REQ_ELEM, 63, 0, x);
	endtask

	initial begin
		logic [6:0] nin_cfg;
		logic [6:0] nout_cfg;
		int phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		hold_go = 1'b0;
		mdl_nin = 7'd64;
		mdl_nout = 7'd64;
		mdl_act = dl_pkg::ACT_RELU;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. A count of zero acts as one, so this is a
		// one-input layer run through every activation with full-scale
		// values that drive the output into saturation. An unknown request
		// goes along and must be ignored.
		for (int m = 0; m < 4; m++) begin
			set_layer(7'd0, 7'd2, 2'(m));
			queue_pair(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff);
			queue_req(REQ_UNKNOWN, 63, 63, 16'shffff);
			queue_pair(16'sh0400, 16'sh8000, 16'sh0000, 16'sh1000, 16'sh0800);
		end
		// Counts above the maximum act as the maximum: 64 inputs into one
		// neuron, then one input fanned out to 64 neurons.
		set_layer(7'd127, 7'd1, dl_pkg::ACT_TANH);
		queue_vector();
		set_layer(7'd1, 7'd127, dl_pkg::ACT_SIGMOID);
		queue_vector();

		// Random part: small layers with random sizes and modes. Two phases
		// run with no gaps at all; a later one carries the long hold-off on
		// results while requests keep coming.
		phase = 0;
		while (queued_items < 400 || phase < 4) begin
			nin_cfg = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(8, 1));
			nout_cfg = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(8, 1));
			if (eff_count(nin_cfg) * eff_count(nout_cfg) > 64)
				nout_cfg = 7'd1;
			set_layer(nin_cfg, nout_cfg, 2'($urandom));
			calm = (phase == 1 || phase == 2);
			if (phase == 3)
				hold_go = 1'b1;
			for (int v = $urandom_range(2, 1); v > 0; v--)
				queue_vector();
			phase++;
		end

		// Drain, then give the block time to show any stray result.
		while (pending_reqs.size() > 0 || req_ch.valid || owed_outputs.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (owed_outputs.size() > 0) begin
			$error("%0d results never arrived", owed_outputs.size());
			errors++;
		end
		$display("Run covered %0d requests over %0d layer evaluations and %0d checked results,",
			reqs_sent, vectors_run, outs_checked);
		$display("across all four activations and sizes from one up to sixty-four.");
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
